[rtl/pwmscan_pkg.sv]
package pwmscan_pkg;

    // default sizes of the matrix store
    localparam int MAX_MOTIF_LEN_DEF = 32;
    localparam int WEIGHT_BITS_DEF   = 16;

    // fixed field widths
    localparam int SUM_BITS   = 21;
    localparam int LEN_BITS   = 6;
    localparam int RECIP_BITS = 32;
    localparam int SCORE_BITS = 32;
    localparam int INDEX_BITS = 32;
    localparam int CFG_IDX_W  = 2;

    // fraction bits of the reciprocal
    localparam int RECIP_FRAC = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP     = 2'd1;

    // item kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_BASE   = 1'b1;

    // base characters
    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_UP = 8'h47;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    // matrix rows
    localparam logic [1:0] ROW_A = 2'd0;
    localparam logic [1:0] ROW_C = 2'd1;
    localparam logic [1:0] ROW_G = 2'd2;
    localparam logic [1:0] ROW_T = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [1:0] row;
    } t_row_lookup;

    // map an ascii base to its matrix row
    function automatic t_row_lookup row_of(input logic [7:0] c);
        t_row_lookup res;
        res.hit = 1'b1;
        res.row = ROW_A;
        case (c) inside
            CHAR_A_UP, CHAR_A_LO: res.row = ROW_A;
            CHAR_C_UP, CHAR_C_LO: res.row = ROW_C;
            CHAR_G_UP, CHAR_G_LO: res.row = ROW_G;
            CHAR_T_UP, CHAR_T_LO: res.row = ROW_T;
            default:              res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

[rtl/pwm_sliding_window_scan_core.sv]
// channel   | dir | handshake                          | payload
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata, tuser = kind, tlast = last_base
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata, tuser = too_short,
//           |     |                                    | tlast = last_window
// cfg       | in  | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// one item is taken per cycle while s_axis is not stalled; a base goes through
// the row read at the take, then sum update, multiply, round and saturate
// the rate is set by the parallel partial-sum adders, one per matrix column
// synchronous active-low reset clears the sequence state and sets the registers
// to their defaults; the weight store is not cleared and holds garbage until written
// a stall on m_axis backs up stage by stage; bubbles are squeezed out, so s_axis
// keeps taking items while a result waits in the output register, until every stage is full
module pwm_sliding_window_scan_core #(
    parameter int MAX_MOTIF_LEN = pwmscan_pkg::MAX_MOTIF_LEN_DEF,
    parameter int WEIGHT_BITS   = pwmscan_pkg::WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // weight_row[1:0], weight_col[6:2], weight_value[22:7], base_char[30:23], first_base[31]
    input  logic [31:0] i_s_axis_tdata,
    // kind[0]
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // raw_sum[20:0], scaled_score[52:21], window_index[84:53], zero fill[87:85]
    output logic [87:0] o_m_axis_tdata,
    // too_short[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwmscan_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    localparam int SUM_W   = pwmscan_pkg::SUM_BITS;
    localparam int LEN_W   = $clog2(MAX_MOTIF_LEN + 1);
    localparam int COL_W   = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int PROD_W  = SUM_W + pwmscan_pkg::RECIP_BITS + 1;
    localparam int Q_W     = PROD_W - pwmscan_pkg::RECIP_FRAC;
    localparam int SCORE_W = pwmscan_pkg::SCORE_BITS;
    localparam int IDX_W   = pwmscan_pkg::INDEX_BITS;

    // input field split
    logic [1:0]        s_row;
    logic [4:0]        s_col;
    logic signed [15:0] s_wval;
    logic [7:0]        s_char;
    logic              s_first;
    assign s_row   = i_s_axis_tdata[1:0];
    assign s_col   = i_s_axis_tdata[6:2];
    assign s_wval  = $signed(i_s_axis_tdata[22:7]);
    assign s_char  = i_s_axis_tdata[30:23];
    assign s_first = i_s_axis_tdata[31];

    // configuration registers
    logic [pwmscan_pkg::LEN_BITS-1:0]   r_motif_len;
    logic [pwmscan_pkg::RECIP_BITS-1:0] r_recip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_len <= pwmscan_pkg::LEN_BITS'(1);
            r_recip     <= pwmscan_pkg::RECIP_BITS'(65536);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pwmscan_pkg::CFG_MOTIF_LEN: r_motif_len <= i_cfg_data[pwmscan_pkg::LEN_BITS-1:0];
                pwmscan_pkg::CFG_RECIP:     r_recip     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic r_s1_v, r_s2_v, r_s3_v, r_o_v;
    logic s1_ready, s2_ready, s3_ready, o_ready;
    logic in_fire, s1_fire, s2_fire, s3_fire;

    assign o_ready  = !r_o_v || i_m_axis_tready;
    assign s3_ready = !r_s3_v || o_ready;
    assign s2_ready = !r_s2_v || s3_ready;
    assign s1_ready = !r_s1_v || s2_ready;

    assign o_s_axis_tready = s1_ready;
    assign in_fire = i_s_axis_tvalid && s1_ready;
    assign s1_fire = r_s1_v && s2_ready;
    assign s2_fire = r_s2_v && s3_ready;
    assign s3_fire = r_s3_v && o_ready;

    // weight store, one wide row per base, one column lane written at a time
    logic signed [WEIGHT_BITS-1:0] r_wt_mem [4][MAX_MOTIF_LEN];
    logic signed [WEIGHT_BITS-1:0] r_s1_wts [MAX_MOTIF_LEN];
    pwmscan_pkg::t_row_lookup      lookup;
    logic                          col_ok;

    assign lookup = pwmscan_pkg::row_of(s_char);
    assign col_ok = int'(s_col) < MAX_MOTIF_LEN;

    always_ff @(posedge i_clk) begin
        if (in_fire && i_s_axis_tuser == pwmscan_pkg::KIND_WEIGHT && col_ok) begin
            r_wt_mem[s_row][COL_W'(s_col)] <= WEIGHT_BITS'(s_wval);
        end
        if (in_fire && i_s_axis_tuser == pwmscan_pkg::KIND_BASE) begin
            r_s1_wts <= r_wt_mem[lookup.row];
        end
    end

    // stage 1 control: base items only
    logic r_s1_hit, r_s1_first, r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= in_fire && i_s_axis_tuser == pwmscan_pkg::KIND_BASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_hit   <= lookup.hit;
            r_s1_first <= s_first;
            r_s1_last  <= i_s_axis_tlast;
        end
    end

    // effective window length
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_m1;

    always_comb begin
        if (r_motif_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(r_motif_len) > MAX_MOTIF_LEN) begin
            len_eff = LEN_W'(MAX_MOTIF_LEN);
        end else begin
            len_eff = LEN_W'(r_motif_len);
        end
    end
    assign len_m1 = len_eff - LEN_W'(1);

    // running sequence state
    logic signed [SUM_W-1:0] r_ps [MAX_MOTIF_LEN];
    logic [LEN_W-1:0]        r_bs;
    logic [IDX_W-1:0]        r_wc;

    logic signed [SUM_W-1:0] ps_base [MAX_MOTIF_LEN];
    logic signed [SUM_W-1:0] w_col   [MAX_MOTIF_LEN];
    logic signed [SUM_W-1:0] n_ps    [MAX_MOTIF_LEN];
    logic [LEN_W-1:0]        bs_base, n_bs;
    logic [IDX_W-1:0]        wc_base;
    logic                    win_hit;

    // partial sums shift one column per base, each column adds its weight
    always_comb begin
        for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
            ps_base[j] = r_s1_first ? '0 : r_ps[j];
            w_col[j]   = r_s1_hit ? SUM_W'(r_s1_wts[j]) : '0;
        end
        n_ps[0] = w_col[0];
        for (int j = 1; j < MAX_MOTIF_LEN; j++) begin
            n_ps[j] = (j < int'(len_eff)) ? ps_base[j-1] + w_col[j] : ps_base[j];
        end
        bs_base = r_s1_first ? '0 : r_bs;
        wc_base = r_s1_first ? '0 : r_wc;
        n_bs    = (int'(bs_base) < MAX_MOTIF_LEN) ? bs_base + LEN_W'(1) : bs_base;
        win_hit = n_bs >= len_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
                r_ps[j] <= '0;
            end
            r_bs <= '0;
            r_wc <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                for (int j = 0; j < MAX_MOTIF_LEN; j++) begin
                    r_ps[j] <= '0;
                end
                r_bs <= '0;
                r_wc <= '0;
            end else begin
                r_ps <= n_ps;
                r_bs <= n_bs;
                r_wc <= win_hit ? wc_base + IDX_W'(1) : wc_base;
            end
        end
    end

    // stage 2: window result
    logic signed [SUM_W-1:0] r_s2_raw;
    logic [IDX_W-1:0]        r_s2_idx;
    logic                    r_s2_last, r_s2_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= s1_fire && (win_hit || r_s1_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_raw   <= win_hit ? n_ps[len_m1[COL_W-1:0]] : '0;
            r_s2_idx   <= win_hit ? wc_base : '0;
            r_s2_last  <= r_s1_last;
            r_s2_short <= !win_hit;
        end
    end

    // stage 3: scale multiply
    logic signed [PROD_W-1:0] r_s3_prod;
    logic signed [SUM_W-1:0]  r_s3_raw;
    logic [IDX_W-1:0]         r_s3_idx;
    logic                     r_s3_last, r_s3_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s3_ready) begin
            r_s3_v <= s2_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_s3_prod  <= PROD_W'(r_s2_raw * $signed({1'b0, r_recip}));
            r_s3_raw   <= r_s2_raw;
            r_s3_idx   <= r_s2_idx;
            r_s3_last  <= r_s2_last;
            r_s3_short <= r_s2_short;
        end
    end

    // floor shift and saturate to 32 bits
    logic signed [Q_W-1:0]     q_full;
    logic signed [SCORE_W-1:0] q_sat;

    assign q_full = r_s3_prod[PROD_W-1:pwmscan_pkg::RECIP_FRAC];

    always_comb begin
        if (q_full[Q_W-1:SCORE_W-1] == {(Q_W-SCORE_W+1){q_full[SCORE_W-1]}}) begin
            q_sat = q_full[SCORE_W-1:0];
        end else if (q_full[Q_W-1]) begin
            q_sat = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    // output register
    logic signed [SUM_W-1:0]   r_o_raw;
    logic signed [SCORE_W-1:0] r_o_score;
    logic [IDX_W-1:0]          r_o_idx;
    logic                      r_o_last, r_o_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_ready) begin
            r_o_v <= s3_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_fire) begin
            r_o_raw   <= r_s3_raw;
            r_o_score <= q_sat;
            r_o_idx   <= r_s3_idx;
            r_o_last  <= r_s3_last;
            r_o_short <= r_s3_short;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {3'b000, r_o_idx, r_o_score, r_o_raw};
    assign o_m_axis_tuser  = r_o_short;
    assign o_m_axis_tlast  = r_o_last;

    // checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> (r_bs == '0 && r_wc == '0))
        else $error("sequence state not cleared after last base");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_v && r_s2_v && r_s3_v && r_o_v))
        else $error("input stalled while a pipeline stage is empty");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_short) |-> (r_o_last && r_o_raw == '0 && r_o_idx == '0))
        else $error("short-sequence result carries data");

    a_score_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_raw[SUM_W-1] ? (r_o_score[SCORE_W-1] || r_o_score == '0)
                                     : !r_o_score[SCORE_W-1]))
        else $error("scaled score sign differs from raw sum");

    a_bases_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (int'(r_bs) <= MAX_MOTIF_LEN))
        else $error("bases seen past matrix width");

endmodule
